[src/assert_macros.svh]
// Assertion macros for the light pulse code decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define LPCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define LPCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/lpcd_pkg.sv]
// Types and constants shared by the light pulse code decoder.
`timescale 1ns / 1ps
`default_nettype none

package lpcd_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int MAX_COUNT_DEF   = 5;

  localparam int THRESH_W    = 10;
  localparam int TICK_W      = 8;
  localparam int COUNT_W     = 3;
  localparam int CODE_W      = 2;
  localparam int US_W        = 11;
  localparam int TABLE_W     = 50;
  localparam int WIDTHS_W    = 44;
  localparam int TABLE_SIZE  = 25;
  localparam int CFG_DATA_W  = 50;
  localparam int CFG_INDEX_W = 3;

  localparam logic [US_W-1:0] CENTER_US = 11'd1500;

  localparam logic [THRESH_W-1:0] RST_LIGHT_TRIP        = 10'd520;
  localparam logic [TICK_W-1:0]   RST_SHORT_MAX_TICKS   = 8'd18;
  localparam logic [TICK_W-1:0]   RST_LONG_MIN_TICKS    = 8'd28;
  localparam logic [TICK_W-1:0]   RST_GAP_END_TICKS     = 8'd140;
  localparam logic [TICK_W-1:0]   RST_ON_CAP_TICKS      = 8'd200;
  localparam logic [TABLE_W-1:0]  RST_ZONE_TABLE        = 50'd645513958824464;
  localparam logic [WIDTHS_W-1:0] RST_ZONE_PULSE_WIDTHS = 44'd16224556377175;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LIGHT_TRIP        = 3'd0,
    REG_SHORT_MAX_TICKS   = 3'd1,
    REG_LONG_MIN_TICKS    = 3'd2,
    REG_GAP_END_TICKS     = 3'd3,
    REG_ON_CAP_TICKS      = 3'd4,
    REG_ZONE_TABLE        = 3'd5,
    REG_ZONE_PULSE_WIDTHS = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  typedef enum logic [CODE_W-1:0] {
    ZONE_A = 2'd0,
    ZONE_B = 2'd1,
    ZONE_C = 2'd2,
    ZONE_D = 2'd3
  } zone_t;

  typedef struct packed {
    logic [THRESH_W-1:0] light_trip;
    logic [TICK_W-1:0]   short_max_ticks;
    logic [TICK_W-1:0]   long_min_ticks;
    logic [TICK_W-1:0]   gap_end_ticks;
    logic [TICK_W-1:0]   on_cap_ticks;
    logic [TABLE_W-1:0]  zone_table;
    logic [WIDTHS_W-1:0] zone_pulse_widths;
  } cfg_t;

  // Burst end report from the tracker.
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] short_pulses;
    logic [COUNT_W-1:0] long_pulses;
  } burst_t;

endpackage

`default_nettype wire

[src/lpcd_if.sv]
// Valid/ready channel interfaces for samples and decoded results.
`timescale 1ns / 1ps
`default_nettype none

interface lpcd_sample_if import lpcd_pkg::*;
  #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] light_level;

  modport source (output valid, output light_level, input ready);
  modport sink   (input valid, input light_level, output ready);
endinterface

interface lpcd_result_if import lpcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  zone_code;
  logic               zone_valid;
  logic [US_W-1:0]    servo_pulse_us;
  logic [COUNT_W-1:0] short_pulses;
  logic [COUNT_W-1:0] long_pulses;

  modport source (output valid, output zone_code, output zone_valid, output servo_pulse_us,
                  output short_pulses, output long_pulses, input ready);
  modport sink   (input valid, input zone_code, input zone_valid, input servo_pulse_us,
                  input short_pulses, input long_pulses, output ready);
endinterface

`default_nettype wire

[src/lpcd_tracker.sv]
// Pulse and gap timing state machine with short/long pulse counters.
`timescale 1ns / 1ps
`default_nettype none

module lpcd_tracker import lpcd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_COUNT   = MAX_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire cfg_t                   cfg,
  output burst_t                      burst
);

  localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam logic [COUNT_W-1:0] COUNT_SAT =
    COUNT_W'((MAX_COUNT + 1 > 7) ? 7 : MAX_COUNT + 1);

  phase_t             phase, phase_next;
  logic [TICK_W-1:0]  on_ticks, on_ticks_next;
  logic [TICK_W-1:0]  gap_ticks, gap_ticks_next;
  logic [COUNT_W-1:0] short_count, short_count_next;
  logic [COUNT_W-1:0] long_count, long_count_next;

  logic              light;
  logic [TICK_W:0]   on_inc;
  logic [TICK_W:0]   gap_inc;
  logic [TICK_W:0]   limit_sum;
  logic [TICK_W-1:0] midpoint;
  logic              is_short;
  logic              cap_at_start;
  logic [COUNT_W-1:0] short_cls, long_cls;

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (c < COUNT_SAT) ? c + COUNT_W'(1) : c;
  endfunction

  assign light     = CMP_W'(sample) > CMP_W'(cfg.light_trip);
  assign on_inc    = {1'b0, on_ticks} + (TICK_W+1)'(1);
  assign gap_inc   = {1'b0, gap_ticks} + (TICK_W+1)'(1);
  assign limit_sum = {1'b0, cfg.short_max_ticks} + {1'b0, cfg.long_min_ticks};
  assign midpoint  = limit_sum[TICK_W:1];
  assign is_short  = (on_ticks <= cfg.short_max_ticks) ||
                     ((on_ticks < cfg.long_min_ticks) && (on_ticks < midpoint));
  assign short_cls = is_short ? bump(short_count) : short_count;
  assign long_cls  = is_short ? long_count : bump(long_count);
  // first light tick already passes the cap
  assign cap_at_start = (cfg.on_cap_ticks == '0);

  always_comb begin
    phase_next       = phase;
    on_ticks_next    = on_ticks;
    gap_ticks_next   = gap_ticks;
    short_count_next = short_count;
    long_count_next  = long_count;
    burst            = '0;
    case (phase)
      PH_ON: begin
        if (light) begin
          if (on_inc > {1'b0, cfg.on_cap_ticks}) begin
            long_count_next = bump(long_count);
            on_ticks_next   = '0;
            gap_ticks_next  = '0;
            phase_next      = PH_GAP;
          end else begin
            on_ticks_next = on_inc[TICK_W-1:0];
          end
        end else if (cfg.gap_end_ticks == '0) begin
          burst.done         = 1'b1;
          burst.short_pulses = short_cls;
          burst.long_pulses  = long_cls;
          phase_next         = PH_IDLE;
          on_ticks_next      = '0;
          gap_ticks_next     = '0;
          short_count_next   = '0;
          long_count_next    = '0;
        end else begin
          short_count_next = short_cls;
          long_count_next  = long_cls;
          on_ticks_next    = '0;
          gap_ticks_next   = TICK_W'(1);
          phase_next       = PH_GAP;
        end
      end
      PH_GAP: begin
        if (light) begin
          gap_ticks_next = '0;
          if (cap_at_start) begin
            long_count_next = bump(long_count);
            on_ticks_next   = '0;
          end else begin
            on_ticks_next = TICK_W'(1);
            phase_next    = PH_ON;
          end
        end else if (gap_inc > {1'b0, cfg.gap_end_ticks}) begin
          burst.done         = 1'b1;
          burst.short_pulses = short_count;
          burst.long_pulses  = long_count;
          phase_next         = PH_IDLE;
          on_ticks_next      = '0;
          gap_ticks_next     = '0;
          short_count_next   = '0;
          long_count_next    = '0;
        end else begin
          gap_ticks_next = gap_inc[TICK_W-1:0];
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (light) begin
          gap_ticks_next   = '0;
          short_count_next = '0;
          if (cap_at_start) begin
            long_count_next = COUNT_W'(1);
            on_ticks_next   = '0;
            phase_next      = PH_GAP;
          end else begin
            long_count_next = '0;
            on_ticks_next   = TICK_W'(1);
            phase_next      = PH_ON;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      on_ticks    <= '0;
      gap_ticks   <= '0;
      short_count <= '0;
      long_count  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      on_ticks    <= on_ticks_next;
      gap_ticks   <= gap_ticks_next;
      short_count <= short_count_next;
      long_count  <= long_count_next;
    end
  end

endmodule

`default_nettype wire

[src/lpcd_zone_lookup.sv]
// Maps the short/long pulse counts to a zone code and servo pulse width.
`timescale 1ns / 1ps
`default_nettype none

module lpcd_zone_lookup import lpcd_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  wire logic [COUNT_W-1:0]  short_pulses,
  input  wire logic [COUNT_W-1:0]  long_pulses,
  input  wire logic [TABLE_W-1:0]  zone_table,
  input  wire logic [WIDTHS_W-1:0] zone_pulse_widths,
  output zone_t                    zone_code,
  output logic                     zone_valid,
  output logic [US_W-1:0]          servo_pulse_us
);

  localparam int IDX_W = 6;
  localparam logic [COUNT_W-1:0] MAX_C = COUNT_W'(MAX_COUNT);
  localparam logic [IDX_W-1:0]   MAX_I = IDX_W'(MAX_COUNT);

  logic [IDX_W-1:0]   idx;
  logic [TABLE_W-1:0] shifted;
  zone_t              entry;

  assign zone_valid = (short_pulses != '0) && (short_pulses <= MAX_C) &&
                      (long_pulses != '0) && (long_pulses <= MAX_C);
  assign idx = IDX_W'((IDX_W'(short_pulses) - IDX_W'(1)) * MAX_I +
                      IDX_W'(long_pulses) - IDX_W'(1));
  assign shifted = zone_table >> {idx, 1'b0};
  assign entry   = (idx < IDX_W'(TABLE_SIZE)) ? zone_t'(shifted[CODE_W-1:0]) : ZONE_A;

  always_comb begin
    zone_code      = ZONE_A;
    servo_pulse_us = CENTER_US;
    if (zone_valid) begin
      zone_code = entry;
      case (entry)
        ZONE_A:  servo_pulse_us = zone_pulse_widths[0*US_W +: US_W];
        ZONE_B:  servo_pulse_us = zone_pulse_widths[1*US_W +: US_W];
        ZONE_C:  servo_pulse_us = zone_pulse_widths[2*US_W +: US_W];
        ZONE_D:  servo_pulse_us = zone_pulse_widths[3*US_W +: US_W];
        default: servo_pulse_us = CENTER_US;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/light_pulse_code_decoder_unit.sv]
// Top level of the light pulse code decoder.
`timescale 1ns / 1ps
`default_nettype none

// One light sample per millisecond tick arrives on light_in; a sample above
// light_trip counts as light. Light pulses are timed and sorted short or
// long, and a dark gap longer than gap_end_ticks ends the burst, which gives
// one transfer on zone_out with the zone and servo width for the two counts
// (center width and zone_valid low when a count is outside 1..MAX_COUNT).
// Ticks that do not end a burst give nothing. A sample is taken every cycle
// while the result side keeps up: it is held in the input register, the pulse
// tracker and zone lookup act on it combinationally, and a result is loaded
// into the output register as the sample leaves. A waiting result holds one
// more sample in the input register before light_in.ready drops. The user
// must write registers through cfg_write/cfg_index/cfg_data only while no
// burst is in progress; the block itself does not enforce this.

`include "assert_macros.svh"

module light_pulse_code_decoder_unit import lpcd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_COUNT   = MAX_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  lpcd_sample_if.sink                 light_in,
  lpcd_result_if.source               zone_out
);

  localparam logic [COUNT_W-1:0] COUNT_SAT =
    COUNT_W'((MAX_COUNT + 1 > 7) ? 7 : MAX_COUNT + 1);

  cfg_t cfg;

  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   advance;
  logic                   step;
  burst_t                 burst;

  zone_t              lk_code;
  logic               lk_valid;
  logic [US_W-1:0]    lk_us;

  logic               res_valid;
  zone_t              res_code;
  logic               res_zone_valid;
  logic [US_W-1:0]    res_us;
  logic [COUNT_W-1:0] res_short;
  logic [COUNT_W-1:0] res_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_trip        <= RST_LIGHT_TRIP;
      cfg.short_max_ticks   <= RST_SHORT_MAX_TICKS;
      cfg.long_min_ticks    <= RST_LONG_MIN_TICKS;
      cfg.gap_end_ticks     <= RST_GAP_END_TICKS;
      cfg.on_cap_ticks      <= RST_ON_CAP_TICKS;
      cfg.zone_table        <= RST_ZONE_TABLE;
      cfg.zone_pulse_widths <= RST_ZONE_PULSE_WIDTHS;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        REG_LIGHT_TRIP:        cfg.light_trip        <= cfg_data[THRESH_W-1:0];
        REG_SHORT_MAX_TICKS:   cfg.short_max_ticks   <= cfg_data[TICK_W-1:0];
        REG_LONG_MIN_TICKS:    cfg.long_min_ticks    <= cfg_data[TICK_W-1:0];
        REG_GAP_END_TICKS:     cfg.gap_end_ticks     <= cfg_data[TICK_W-1:0];
        REG_ON_CAP_TICKS:      cfg.on_cap_ticks      <= cfg_data[TICK_W-1:0];
        REG_ZONE_TABLE:        cfg.zone_table        <= cfg_data[TABLE_W-1:0];
        REG_ZONE_PULSE_WIDTHS: cfg.zone_pulse_widths <= cfg_data[WIDTHS_W-1:0];
        default: ;
      endcase
    end
  end

  // output register free or being emptied this cycle
  assign advance        = !res_valid || zone_out.ready;
  assign step           = in_valid && advance;
  assign light_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (light_in.valid && light_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (light_in.valid && light_in.ready) begin
      sample <= light_in.light_level;
    end
  end

  lpcd_tracker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_COUNT   (MAX_COUNT)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .sample (sample),
    .cfg    (cfg),
    .burst  (burst)
  );

  lpcd_zone_lookup #(
    .MAX_COUNT (MAX_COUNT)
  ) u_lookup (
    .short_pulses      (burst.short_pulses),
    .long_pulses       (burst.long_pulses),
    .zone_table        (cfg.zone_table),
    .zone_pulse_widths (cfg.zone_pulse_widths),
    .zone_code         (lk_code),
    .zone_valid        (lk_valid),
    .servo_pulse_us    (lk_us)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step && burst.done;
    end
  end

  always_ff @(posedge clk) begin
    if (step && burst.done) begin
      res_code       <= lk_code;
      res_zone_valid <= lk_valid;
      res_us         <= lk_us;
      res_short      <= burst.short_pulses;
      res_long       <= burst.long_pulses;
    end
  end

  assign zone_out.valid          = res_valid;
  assign zone_out.zone_code      = res_code;
  assign zone_out.zone_valid     = res_zone_valid;
  assign zone_out.servo_pulse_us = res_us;
  assign zone_out.short_pulses   = res_short;
  assign zone_out.long_pulses    = res_long;

  `LPCD_ASSERT(a_no_result_from_nothing, (!in_valid && !res_valid) |=> !res_valid,
    "result appeared with no sample in flight")
  `LPCD_ASSERT(a_invalid_is_center,
    (res_valid && !res_zone_valid) |-> (res_us == CENTER_US && res_code == ZONE_A),
    "invalid result not at center width")
  `LPCD_ASSERT(a_counts_saturate,
    res_valid |-> (res_short <= COUNT_SAT && res_long <= COUNT_SAT),
    "pulse count above saturation")
  `LPCD_ASSERT_ALWAYS(a_ready_when_empty, !in_valid |-> light_in.ready,
    "input refused with empty input register")

endmodule

`default_nettype wire
